// File: src/gsbd_pkg.sv
// ---------------------------------------------------------------------------
// GCR sector bit decoder package
// Shared types, marks, lengths and the 6-and-2 translate functions.
// ---------------------------------------------------------------------------
package gsbd_pkg;

    localparam int STORE_DEPTH_DEF = 512;

    localparam logic [23:0] MARK_ADDR53 = 24'hd5aab5;
    localparam logic [23:0] MARK_ADDR62 = 24'hd5aa96;
    localparam logic [23:0] MARK_DATA   = 24'hd5aaad;

    localparam logic [8:0] LEN62     = 9'd343;
    localparam logic [8:0] LEN53     = 9'd411;
    localparam logic [8:0] LEN_NONE  = 9'd1;
    localparam logic [8:0] WALK_LAST = 9'd342;
    localparam logic [8:0] AUX_LEN   = 9'd86;
    localparam logic [6:0] AUX_LAST  = 7'd85;
    localparam logic [4:0] WORD_LAST = 5'd31;

    // Parser phase of the bit front end
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ADDR = 2'd1,
        PH_DATA = 2'd2
    } phase_t;

    // Encoding selected by the last address mark
    typedef enum logic [1:0] {
        MODE_NONE = 2'd0,
        MODE_53   = 2'd1,
        MODE_62   = 2'd2
    } mode_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_BITS,
        ST_WALK_RD,
        ST_WALK_WR,
        ST_CHECK,
        ST_EMIT_RD,
        ST_EMIT_ACC,
        ST_OUT
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic step;
        logic walk_wr;
        logic walk_rd;
        logic emit_init;
        logic emit_rd;
        logic emit_acc;
        logic out_fire;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic end62;
        logic walk_last;
        logic sum_ok;
        logic byte_last;
        logic word_last;
    } stat_t;

    // 6-and-2 disk byte to 6-bit value, unknown codes give zero
    function automatic logic [5:0] gcr62_value(input logic [7:0] code);
        logic [5:0] v;
        v = 6'd0;
        unique case (code)
            8'h96: v = 6'd0;   8'h97: v = 6'd1;   8'h9a: v = 6'd2;   8'h9b: v = 6'd3;
            8'h9d: v = 6'd4;   8'h9e: v = 6'd5;   8'h9f: v = 6'd6;   8'ha6: v = 6'd7;
            8'ha7: v = 6'd8;   8'hab: v = 6'd9;   8'hac: v = 6'd10;  8'had: v = 6'd11;
            8'hae: v = 6'd12;  8'haf: v = 6'd13;  8'hb2: v = 6'd14;  8'hb3: v = 6'd15;
            8'hb4: v = 6'd16;  8'hb5: v = 6'd17;  8'hb6: v = 6'd18;  8'hb7: v = 6'd19;
            8'hb9: v = 6'd20;  8'hba: v = 6'd21;  8'hbb: v = 6'd22;  8'hbc: v = 6'd23;
            8'hbd: v = 6'd24;  8'hbe: v = 6'd25;  8'hbf: v = 6'd26;  8'hcb: v = 6'd27;
            8'hcd: v = 6'd28;  8'hce: v = 6'd29;  8'hcf: v = 6'd30;  8'hd3: v = 6'd31;
            8'hd6: v = 6'd32;  8'hd7: v = 6'd33;  8'hd9: v = 6'd34;  8'hda: v = 6'd35;
            8'hdb: v = 6'd36;  8'hdc: v = 6'd37;  8'hdd: v = 6'd38;  8'hde: v = 6'd39;
            8'hdf: v = 6'd40;  8'he5: v = 6'd41;  8'he6: v = 6'd42;  8'he7: v = 6'd43;
            8'he9: v = 6'd44;  8'hea: v = 6'd45;  8'heb: v = 6'd46;  8'hec: v = 6'd47;
            8'hed: v = 6'd48;  8'hee: v = 6'd49;  8'hef: v = 6'd50;  8'hf2: v = 6'd51;
            8'hf3: v = 6'd52;  8'hf4: v = 6'd53;  8'hf5: v = 6'd54;  8'hf6: v = 6'd55;
            8'hf7: v = 6'd56;  8'hf9: v = 6'd57;  8'hfa: v = 6'd58;  8'hfb: v = 6'd59;
            8'hfc: v = 6'd60;  8'hfd: v = 6'd61;  8'hfe: v = 6'd62;  8'hff: v = 6'd63;
            default: v = 6'd0;
        endcase
        return v;
    endfunction

    // Bit pair swap of the auxiliary bytes
    function automatic logic [1:0] swap2(input logic [1:0] v);
        return {v[0], v[1]};
    endfunction

    // 4-and-4 decode
    function automatic logic [7:0] odd_even(input logic [7:0] a, input logic [7:0] b);
        return {a[6:0], 1'b1} & b;
    endfunction

endpackage

// File: src/gsbd_ctrl.sv
// ---------------------------------------------------------------------------
// GCR sector decoder controller
// Sequences bit intake, the decode walk and the word emission.
// ---------------------------------------------------------------------------
module gsbd_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    input  gsbd_pkg::stat_t stat,
    output gsbd_pkg::cmd_t  cmd
);

    gsbd_pkg::state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gsbd_pkg::ST_BITS;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        unique case (state_reg)
            gsbd_pkg::ST_BITS:
            begin
                s_ready  = 1'b1;
                cmd.step = s_valid;
                if (s_valid && stat.end62)
                begin
                    state_next = gsbd_pkg::ST_WALK_RD;
                end
            end
            gsbd_pkg::ST_WALK_RD:
            begin
                cmd.walk_rd = 1'b1;
                state_next  = gsbd_pkg::ST_WALK_WR;
            end
            gsbd_pkg::ST_WALK_WR:
            begin
                cmd.walk_wr = 1'b1;
                state_next  = stat.walk_last ? gsbd_pkg::ST_CHECK : gsbd_pkg::ST_WALK_RD;
            end
            gsbd_pkg::ST_CHECK:
            begin
                cmd.emit_init = 1'b1;
                state_next    = stat.sum_ok ? gsbd_pkg::ST_EMIT_RD : gsbd_pkg::ST_BITS;
            end
            gsbd_pkg::ST_EMIT_RD:
            begin
                cmd.emit_rd = 1'b1;
                state_next  = gsbd_pkg::ST_EMIT_ACC;
            end
            gsbd_pkg::ST_EMIT_ACC:
            begin
                cmd.emit_acc = 1'b1;
                state_next   = stat.byte_last ? gsbd_pkg::ST_OUT : gsbd_pkg::ST_EMIT_RD;
            end
            gsbd_pkg::ST_OUT:
            begin
                m_valid = 1'b1;
                if (m_ready)
                begin
                    cmd.out_fire = 1'b1;
                    state_next   = stat.word_last ? gsbd_pkg::ST_BITS : gsbd_pkg::ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = gsbd_pkg::ST_BITS;
            end
        endcase
    end

endmodule

// File: src/gsbd_dp.sv
// ---------------------------------------------------------------------------
// GCR sector decoder datapath
// Bit window and field parser, byte store, decode walk and word assembly.
// ---------------------------------------------------------------------------
module gsbd_dp
#(
    parameter int STORE_DEPTH = gsbd_pkg::STORE_DEPTH_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  gsbd_pkg::cmd_t  cmd,
    output gsbd_pkg::stat_t stat,
    input  logic            bit_value,
    input  logic [31:0]     stream_position,
    output logic [63:0]     data_word,
    output logic [4:0]      word_index,
    output logic            last_word,
    output logic [7:0]      track_number,
    output logic [7:0]      sector_number,
    output logic [7:0]      id_checksum,
    output logic [31:0]     id_position,
    output logic [31:0]     data_position
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = AW + 1;

    // Parser state
    gsbd_pkg::phase_t phase_reg, phase_next;
    gsbd_pkg::mode_t  mode_reg, mode_next;
    logic [23:0] win_reg, win_next;
    logic [5:0]  bcnt_reg, bcnt_next;
    logic [8:0]  byte_cnt_reg, byte_cnt_next;
    logic        id_valid_reg, id_valid_next;
    logic [7:0]  track_reg, track_next;
    logic [7:0]  sector_reg, sector_next;
    logic [7:0]  sum_reg, sum_next;
    logic [31:0] id_pos_reg, id_pos_next;
    logic [31:0] data_pos_reg, data_pos_next;
    logic [7:0]  addr_byte_reg [8];

    // Walk and emit state
    logic [8:0]  walk_idx_reg, walk_idx_next;
    logic [7:0]  prev_reg, prev_next;
    logic        emit_idv_reg, emit_idv_next;
    logic [31:0] emit_pos_reg, emit_pos_next;
    logic [7:0]  j_reg, j_next;
    logic [6:0]  aux_idx_reg, aux_idx_next;
    logic [1:0]  seg_reg, seg_next;
    logic [4:0]  word_cnt_reg, word_cnt_next;
    logic [63:0] word_reg, word_next;

    // Memories
    logic [7:0]    store_mem [STORE_DEPTH];
    logic [7:0]    aux_mem [86];
    logic [7:0]    st_rd_reg, aux_rd_reg;
    logic          st_we;
    logic [AW-1:0] st_wa, st_ra;
    logic [7:0]    st_wd;

    // Step helpers
    logic [5:0]  bc;
    logic        take;
    logic [8:0]  bcnt_inc;
    logic [8:0]  need;
    logic [7:0]  sum_c, chk_c;
    logic        end62;
    logic [7:0]  dec_c;
    logic [7:0]  emit_byte;
    logic [7:0]  aux_sh;

    assign dec_c  = {2'b00, gsbd_pkg::gcr62_value(st_rd_reg)} ^ prev_reg;
    assign aux_sh = aux_rd_reg >> {seg_reg, 1'b0};
    assign emit_byte = {st_rd_reg[5:0], 2'b00} | {6'd0, gsbd_pkg::swap2(aux_sh[1:0])};

    // Bit step, walk and emit next-state logic
    always_comb
    begin
        phase_next    = phase_reg;
        mode_next     = mode_reg;
        win_next      = win_reg;
        bcnt_next     = bcnt_reg;
        byte_cnt_next = byte_cnt_reg;
        id_valid_next = id_valid_reg;
        track_next    = track_reg;
        sector_next   = sector_reg;
        sum_next      = sum_reg;
        id_pos_next   = id_pos_reg;
        data_pos_next = data_pos_reg;
        walk_idx_next = walk_idx_reg;
        prev_next     = prev_reg;
        emit_idv_next = emit_idv_reg;
        emit_pos_next = emit_pos_reg;
        j_next        = j_reg;
        aux_idx_next  = aux_idx_reg;
        seg_next      = seg_reg;
        word_cnt_next = word_cnt_reg;
        word_next     = word_reg;
        st_we         = 1'b0;
        st_wa         = AW'(walk_idx_reg);
        st_wd         = dec_c;
        end62         = 1'b0;
        bc            = bcnt_reg + 6'd1;
        take          = (bc == 6'd8);
        bcnt_inc      = byte_cnt_reg + 9'd1;
        win_next      = {win_reg[22:0], bit_value};
        sum_c = gsbd_pkg::odd_even(addr_byte_reg[0], addr_byte_reg[1])
              ^ gsbd_pkg::odd_even(addr_byte_reg[2], addr_byte_reg[3])
              ^ gsbd_pkg::odd_even(addr_byte_reg[4], addr_byte_reg[5]);
        chk_c = gsbd_pkg::odd_even(addr_byte_reg[6], win_next[7:0]);
        unique case (mode_reg)
            gsbd_pkg::MODE_62: need = gsbd_pkg::LEN62;
            gsbd_pkg::MODE_53: need = gsbd_pkg::LEN53;
            default:           need = gsbd_pkg::LEN_NONE;
        endcase

        if (cmd.step)
        begin
            // Store write for a completed byte inside a field
            if (take && (phase_reg == gsbd_pkg::PH_ADDR || phase_reg == gsbd_pkg::PH_DATA)
                && (CW'(byte_cnt_reg) < CW'(STORE_DEPTH)))
            begin
                st_we = 1'b1;
                st_wa = AW'(byte_cnt_reg);
                st_wd = win_next[7:0];
            end
            unique case (phase_reg)
                gsbd_pkg::PH_ADDR:
                begin
                    if (take)
                    begin
                        byte_cnt_next = bcnt_inc;
                        bc            = 6'd0;
                        if (byte_cnt_reg == 9'd7)
                        begin
                            if (chk_c == sum_c)
                            begin
                                track_next    = gsbd_pkg::odd_even(addr_byte_reg[2],
                                                                   addr_byte_reg[3]);
                                sector_next   = gsbd_pkg::odd_even(addr_byte_reg[4],
                                                                   addr_byte_reg[5]);
                                sum_next      = sum_c;
                                id_valid_next = 1'b1;
                            end
                            else
                            begin
                                id_pos_next   = 32'd0;
                                id_valid_next = 1'b0;
                            end
                            phase_next = gsbd_pkg::PH_IDLE;
                        end
                    end
                end
                gsbd_pkg::PH_DATA:
                begin
                    if (take)
                    begin
                        byte_cnt_next = bcnt_inc;
                        bc            = 6'd0;
                        if (bcnt_inc >= need)
                        begin
                            if (mode_reg == gsbd_pkg::MODE_62)
                            begin
                                end62         = 1'b1;
                                emit_idv_next = id_valid_reg;
                                emit_pos_next = id_pos_reg;
                                walk_idx_next = 9'd0;
                                prev_next     = 8'd0;
                            end
                            id_pos_next   = 32'd0;
                            id_valid_next = 1'b0;
                            phase_next    = gsbd_pkg::PH_IDLE;
                        end
                    end
                end
                default:
                begin
                    phase_next = gsbd_pkg::PH_IDLE;
                    if (bc >= 6'd24)
                    begin
                        if (win_next == gsbd_pkg::MARK_ADDR53 || win_next == gsbd_pkg::MARK_ADDR62)
                        begin
                            mode_next     = (win_next == gsbd_pkg::MARK_ADDR53) ?
                                            gsbd_pkg::MODE_53 : gsbd_pkg::MODE_62;
                            phase_next    = gsbd_pkg::PH_ADDR;
                            byte_cnt_next = 9'd0;
                            bc            = 6'd0;
                            id_pos_next   = stream_position;
                            id_valid_next = 1'b0;
                        end
                        else if (win_next == gsbd_pkg::MARK_DATA)
                        begin
                            phase_next    = gsbd_pkg::PH_DATA;
                            byte_cnt_next = 9'd0;
                            bc            = 6'd0;
                            data_pos_next = stream_position;
                        end
                    end
                end
            endcase
            bcnt_next = (bc > 6'd32) ? 6'd32 : bc;
        end
        else
        begin
            win_next = win_reg;
        end

        // Decode walk: translate, chain, write back
        if (cmd.walk_wr)
        begin
            st_we         = 1'b1;
            st_wa         = AW'(walk_idx_reg);
            st_wd         = dec_c;
            prev_next     = dec_c;
            walk_idx_next = walk_idx_reg + 9'd1;
        end

        // Emission counters
        if (cmd.emit_init)
        begin
            j_next        = 8'd0;
            aux_idx_next  = 7'd0;
            seg_next      = 2'd0;
            word_cnt_next = 5'd0;
        end
        if (cmd.emit_acc)
        begin
            word_next = {emit_byte, word_reg[63:8]};
            j_next    = j_reg + 8'd1;
            if (aux_idx_reg == gsbd_pkg::AUX_LAST)
            begin
                aux_idx_next = 7'd0;
                seg_next     = seg_reg + 2'd1;
            end
            else
            begin
                aux_idx_next = aux_idx_reg + 7'd1;
            end
        end
        if (cmd.out_fire)
        begin
            word_cnt_next = word_cnt_reg + 5'd1;
        end
    end

    // Read address: walk index or upper part of the sector
    assign st_ra = cmd.walk_rd ? AW'(walk_idx_reg) : AW'(gsbd_pkg::AUX_LEN + {1'b0, j_reg});

    // Byte store
    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            store_mem[st_wa] <= st_wd;
        end
        st_rd_reg <= store_mem[st_ra];
    end

    // Auxiliary store for the first 86 decoded values
    always_ff @(posedge clk)
    begin
        if (cmd.walk_wr && (walk_idx_reg < gsbd_pkg::AUX_LEN))
        begin
            aux_mem[walk_idx_reg[6:0]] <= dec_c;
        end
        aux_rd_reg <= aux_mem[aux_idx_reg];
    end

    // Address field bytes
    always_ff @(posedge clk)
    begin
        if (cmd.step && take && phase_reg == gsbd_pkg::PH_ADDR && byte_cnt_reg < 9'd8)
        begin
            addr_byte_reg[byte_cnt_reg[2:0]] <= win_next[7:0];
        end
    end

    // Control and held state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= gsbd_pkg::PH_IDLE;
            mode_reg     <= gsbd_pkg::MODE_NONE;
            win_reg      <= 24'd0;
            bcnt_reg     <= 6'd0;
            byte_cnt_reg <= 9'd0;
            id_valid_reg <= 1'b0;
            track_reg    <= 8'd0;
            sector_reg   <= 8'd0;
            sum_reg      <= 8'd0;
            id_pos_reg   <= 32'd0;
            data_pos_reg <= 32'd0;
            walk_idx_reg <= 9'd0;
            emit_idv_reg <= 1'b0;
            j_reg        <= 8'd0;
            aux_idx_reg  <= 7'd0;
            seg_reg      <= 2'd0;
            word_cnt_reg <= 5'd0;
        end
        else
        begin
            phase_reg    <= phase_next;
            mode_reg     <= mode_next;
            win_reg      <= win_next;
            bcnt_reg     <= bcnt_next;
            byte_cnt_reg <= byte_cnt_next;
            id_valid_reg <= id_valid_next;
            track_reg    <= track_next;
            sector_reg   <= sector_next;
            sum_reg      <= sum_next;
            id_pos_reg   <= id_pos_next;
            data_pos_reg <= data_pos_next;
            walk_idx_reg <= walk_idx_next;
            emit_idv_reg <= emit_idv_next;
            j_reg        <= j_next;
            aux_idx_reg  <= aux_idx_next;
            seg_reg      <= seg_next;
            word_cnt_reg <= word_cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        prev_reg     <= prev_next;
        emit_pos_reg <= emit_pos_next;
        word_reg     <= word_next;
    end

    // Status
    assign stat.end62     = end62;
    assign stat.walk_last = (walk_idx_reg == gsbd_pkg::WALK_LAST);
    assign stat.sum_ok    = (prev_reg == 8'd0) && emit_idv_reg;
    assign stat.byte_last = (j_reg[2:0] == 3'd7);
    assign stat.word_last = (word_cnt_reg == gsbd_pkg::WORD_LAST);

    // Result fields
    assign data_word     = word_reg;
    assign word_index    = word_cnt_reg;
    assign last_word     = (word_cnt_reg == gsbd_pkg::WORD_LAST);
    assign track_number  = track_reg;
    assign sector_number = sector_reg;
    assign id_checksum   = sum_reg;
    assign id_position   = emit_pos_reg;
    assign data_position = data_pos_reg;

endmodule

// File: src/gcr_sector_bit_decoder.sv
// ---------------------------------------------------------------------------
// GCR sector bit decoder
// Finds address and data marks in a disk bit stream and emits 6-and-2 sectors.
// ---------------------------------------------------------------------------
// Usage:
//   The slave channel takes one disk bit per beat with its stream position.
//   A bit beat is taken whenever s_axis_tvalid is high while the decoder is
//   scanning or collecting a field. The beat that completes a 6-and-2 data
//   field starts the decode walk: each stored byte is read, then written back
//   decoded, and a checksum test follows. While walking and emitting,
//   s_axis_tready is low.
//   A good sector leaves on the master channel as 32 beats of eight bytes;
//   each word is assembled from eight store reads, each followed by an
//   accumulate step, before it is shown.
//   A stalled receiver holds the current word; assembly of the next word
//   does not start until the word is taken. tlast marks word 31.
//   Reset clears the parser, the held address field and the controller;
//   the byte store needs no clearing.
// ---------------------------------------------------------------------------
module gcr_sector_bit_decoder
#(
    parameter int STORE_DEPTH = gsbd_pkg::STORE_DEPTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [39:0]  s_axis_tdata,  // bit_value[0], stream_position[32:1]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [159:0] m_axis_tdata,  // data_word[63:0], word_index[68:64],
                                        // track_number[76:69], sector_number[84:77],
                                        // id_checksum[92:85], id_position[124:93],
                                        // data_position[156:125]
    output logic         m_axis_tlast   // last_word
);

    gsbd_pkg::cmd_t  cmd;
    gsbd_pkg::stat_t stat;
    logic [63:0] data_word;
    logic [4:0]  word_index;
    logic [7:0]  track_number, sector_number, id_checksum;
    logic [31:0] id_position, data_position;

    // Controller
    gsbd_ctrl u_ctrl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Datapath
    gsbd_dp #(.STORE_DEPTH(STORE_DEPTH)) u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .bit_value       (s_axis_tdata[0]),
        .stream_position (s_axis_tdata[32:1]),
        .data_word       (data_word),
        .word_index      (word_index),
        .last_word       (m_axis_tlast),
        .track_number    (track_number),
        .sector_number   (sector_number),
        .id_checksum     (id_checksum),
        .id_position     (id_position),
        .data_position   (data_position)
    );

    // Output beat packing
    assign m_axis_tdata = {3'd0, data_position, id_position, id_checksum,
                           sector_number, track_number, word_index, data_word};

    // Checks
    assert property (@(posedge clk) disable iff (!rst_n) m_axis_tvalid |-> !s_axis_tready)
        else $error("bit intake open while a word is offered");
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[68:64] == 5'd31)
        else $error("tlast on a word other than the last");
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready && !m_axis_tvalid)
        else $error("decoder did not return to bit intake after a sector");
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> !m_axis_tvalid)
        else $error("next word shown without assembly");

endmodule

// File: sim/gsbd_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// GCR sector bit decoder checker
// Watches both stream channels, models the mark search, the address and
// data field parsing and the 6-and-2 sector rebuild, and compares every
// output beat field by field with the oldest predicted word.
// ---------------------------------------------------------------------------
module gsbd_checker
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [39:0]  s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [159:0] m_tdata,
    input  logic         m_tlast,
    output int           fail_count,
    output int           pending,
    output int           words_seen,
    output int           bits_seen
);

    // 6-and-2 disk codes, indexed by 6-bit value
    localparam logic [7:0] GCR_CODES [64] = '{
        8'h96, 8'h97, 8'h9a, 8'h9b, 8'h9d, 8'h9e, 8'h9f, 8'ha6,
        8'ha7, 8'hab, 8'hac, 8'had, 8'hae, 8'haf, 8'hb2, 8'hb3,
        8'hb4, 8'hb5, 8'hb6, 8'hb7, 8'hb9, 8'hba, 8'hbb, 8'hbc,
        8'hbd, 8'hbe, 8'hbf, 8'hcb, 8'hcd, 8'hce, 8'hcf, 8'hd3,
        8'hd6, 8'hd7, 8'hd9, 8'hda, 8'hdb, 8'hdc, 8'hdd, 8'hde,
        8'hdf, 8'he5, 8'he6, 8'he7, 8'he9, 8'hea, 8'heb, 8'hec,
        8'hed, 8'hee, 8'hef, 8'hf2, 8'hf3, 8'hf4, 8'hf5, 8'hf6,
        8'hf7, 8'hf9, 8'hfa, 8'hfb, 8'hfc, 8'hfd, 8'hfe, 8'hff
    };

    typedef struct {
        logic [63:0] data_word;
        logic [4:0]  word_index;
        logic        last_word;
        logic [7:0]  track_number;
        logic [7:0]  sector_number;
        logic [7:0]  id_checksum;
        logic [31:0] id_position;
        logic [31:0] data_position;
    } sector_word_t;

    sector_word_t sector_words_due[$];

    // decoder model state
    gsbd_pkg::phase_t phase;
    gsbd_pkg::mode_t  mode;
    logic [23:0] window;
    int unsigned bit_cnt;
    logic [8:0]  byte_cnt;
    logic [7:0]  field_bytes [512];
    logic        id_ok;
    logic [7:0]  trk_q, sec_q, cks_q;
    logic [31:0] id_pos_q, data_pos_q;

    assign pending = sector_words_due.size();

    function automatic logic [5:0] code_to_value(input logic [7:0] code);
        for (int k = 0; k < 64; k++)
            if (GCR_CODES[k] == code)
                return 6'(k);
        return 6'd0;
    endfunction

    function automatic logic [7:0] four_and_four(input logic [7:0] a, input logic [7:0] b);
        return ((a << 1) | 8'h01) & b;
    endfunction

    // rebuild 256 bytes from the 343 stored disk bytes, queue 32 words if good
    task automatic rebuild_sector();
        logic [7:0]  chain [343];
        logic [7:0]  out_bytes [257];
        logic [7:0]  v;
        sector_word_t w;
        for (int i = 0; i < 257; i++)
            out_bytes[i] = 8'h00;
        for (int i = 0; i < 343; i++)
        begin
            chain[i] = {2'b00, code_to_value(field_bytes[i])};
            if (i > 0)
                chain[i] = chain[i] ^ chain[i-1];
        end
        if (chain[342] != 8'h00 || !id_ok)
            return;
        for (int i = 0; i < 86; i++)
        begin
            v = chain[i];
            if (i < 84)
                out_bytes[i+172] |= {6'd0, v[4], v[5]};
            out_bytes[i+86] |= {6'd0, v[2], v[3]};
            out_bytes[i]    |= {6'd0, v[0], v[1]};
        end
        for (int i = 86; i < 343; i++)
            out_bytes[i-86] |= chain[i] << 2;
        for (int k = 0; k < 32; k++)
        begin
            for (int j = 0; j < 8; j++)
                w.data_word[8*j +: 8] = out_bytes[8*k + j];
            w.word_index    = 5'(k);
            w.last_word     = (k == 31);
            w.track_number  = trk_q;
            w.sector_number = sec_q;
            w.id_checksum   = cks_q;
            w.id_position   = id_pos_q;
            w.data_position = data_pos_q;
            sector_words_due.push_back(w);
        end
    endtask

    // collect one byte once eight bits are in
    task automatic collect_byte();
        if (bit_cnt == 8)
        begin
            field_bytes[byte_cnt] = window[7:0];
            byte_cnt = byte_cnt + 9'd1;
            bit_cnt = 0;
        end
    endtask

    // one disk bit through the parser
    task automatic decode_bit(input logic b, input logic [31:0] pos);
        logic [7:0]  sum;
        logic [8:0]  need;
        window  = {window[22:0], b};
        bit_cnt = bit_cnt + 1;
        if (phase == gsbd_pkg::PH_ADDR)
        begin
            collect_byte();
            if (byte_cnt >= 9'd8)
            begin
                sum = four_and_four(field_bytes[0], field_bytes[1])
                    ^ four_and_four(field_bytes[2], field_bytes[3])
                    ^ four_and_four(field_bytes[4], field_bytes[5]);
                if (four_and_four(field_bytes[6], field_bytes[7]) == sum)
                begin
                    trk_q = four_and_four(field_bytes[2], field_bytes[3]);
                    sec_q = four_and_four(field_bytes[4], field_bytes[5]);
                    cks_q = sum;
                    id_ok = 1'b1;
                end
                else
                begin
                    id_pos_q = '0;
                    id_ok = 1'b0;
                end
                bit_cnt = 0;
                phase = gsbd_pkg::PH_IDLE;
            end
        end
        else if (phase == gsbd_pkg::PH_DATA)
        begin
            collect_byte();
            need = (mode == gsbd_pkg::MODE_62) ? gsbd_pkg::LEN62 :
                   (mode == gsbd_pkg::MODE_53) ? gsbd_pkg::LEN53 : gsbd_pkg::LEN_NONE;
            if (byte_cnt >= need)
            begin
                if (mode == gsbd_pkg::MODE_62)
                    rebuild_sector();
                id_pos_q = '0;
                id_ok = 1'b0;
                bit_cnt = 0;
                phase = gsbd_pkg::PH_IDLE;
            end
        end
        else if (bit_cnt >= 24)
        begin
            if (window == gsbd_pkg::MARK_ADDR53 || window == gsbd_pkg::MARK_ADDR62)
            begin
                mode = (window == gsbd_pkg::MARK_ADDR53) ? gsbd_pkg::MODE_53
                                                         : gsbd_pkg::MODE_62;
                phase = gsbd_pkg::PH_ADDR;
                byte_cnt = '0;
                bit_cnt = 0;
                id_pos_q = pos;
                id_ok = 1'b0;
            end
            else if (window == gsbd_pkg::MARK_DATA)
            begin
                phase = gsbd_pkg::PH_DATA;
                byte_cnt = '0;
                bit_cnt = 0;
                data_pos_q = pos;
            end
        end
        if (bit_cnt > 32)
            bit_cnt = 32;
    endtask

    task automatic compare_field(input string name, input logic [63:0] exp_v,
                                 input logic [63:0] act_v, input int idx);
        if (exp_v !== act_v)
        begin
            if (fail_count < 10)
                $display("MISMATCH word %0d %s: expected %h, got %h", idx, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // model reset
    initial
    begin
        phase = gsbd_pkg::PH_IDLE;
        mode = gsbd_pkg::MODE_NONE;
        window = '0;
        bit_cnt = 0;
        byte_cnt = '0;
        id_ok = 1'b0;
        trk_q = '0;
        sec_q = '0;
        cks_q = '0;
        id_pos_q = '0;
        data_pos_q = '0;
        fail_count = 0;
        words_seen = 0;
        bits_seen = 0;
        for (int i = 0; i < 512; i++)
            field_bytes[i] = 8'h00;
    end

    // output beats are checked before the input beat of the same edge
    always @(posedge clk)
    begin
        sector_word_t e;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (sector_words_due.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("MISMATCH unexpected output beat, data %h", m_tdata[63:0]);
                    fail_count++;
                end
                else
                begin
                    e = sector_words_due.pop_front();
                    compare_field("data_word",     e.data_word,     m_tdata[63:0],    words_seen);
                    compare_field("word_index",    e.word_index,    m_tdata[68:64],   words_seen);
                    compare_field("track_number",  e.track_number,  m_tdata[76:69],   words_seen);
                    compare_field("sector_number", e.sector_number, m_tdata[84:77],   words_seen);
                    compare_field("id_checksum",   e.id_checksum,   m_tdata[92:85],   words_seen);
                    compare_field("id_position",   e.id_position,   m_tdata[124:93],  words_seen);
                    compare_field("data_position", e.data_position, m_tdata[156:125], words_seen);
                    compare_field("last_word",     e.last_word,     m_tlast,          words_seen);
                end
                words_seen++;
            end
            if (s_tvalid && s_tready)
            begin
                decode_bit(s_tdata[0], s_tdata[32:1]);
                bits_seen++;
            end
        end
    end

endmodule

// File: sim/tb_gcr_sector_bit_decoder.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// GCR sector bit decoder testbench
// Streams disk bits built from address and data fields (good, corrupted,
// 5-and-3, missing ID, unknown codes) plus noise, with random gaps and
// receiver stalls; the checker predicts and compares every sector word.
// ---------------------------------------------------------------------------
module tb_gcr_sector_bit_decoder;

    localparam logic [7:0] GCR_CODES [64] = '{
        8'h96, 8'h97, 8'h9a, 8'h9b, 8'h9d, 8'h9e, 8'h9f, 8'ha6,
        8'ha7, 8'hab, 8'hac, 8'had, 8'hae, 8'haf, 8'hb2, 8'hb3,
        8'hb4, 8'hb5, 8'hb6, 8'hb7, 8'hb9, 8'hba, 8'hbb, 8'hbc,
        8'hbd, 8'hbe, 8'hbf, 8'hcb, 8'hcd, 8'hce, 8'hcf, 8'hd3,
        8'hd6, 8'hd7, 8'hd9, 8'hda, 8'hdb, 8'hdc, 8'hdd, 8'hde,
        8'hdf, 8'he5, 8'he6, 8'he7, 8'he9, 8'hea, 8'heb, 8'hec,
        8'hed, 8'hee, 8'hef, 8'hf2, 8'hf3, 8'hf4, 8'hf5, 8'hf6,
        8'hf7, 8'hf9, 8'hfa, 8'hfb, 8'hfc, 8'hfd, 8'hfe, 8'hff
    };

    // kinds of data field
    typedef enum int {
        DF_GOOD,
        DF_BAD_SUM,
        DF_UNKNOWN,
        DF_53
    } field_kind_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [39:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [159:0] m_axis_tdata;
    logic         m_axis_tlast;

    int fail_count, pending, words_seen, bits_seen;
    int sectors_sent;
    bit burst;

    gcr_sector_bit_decoder dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    gsbd_checker chk
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_axis_tvalid),
        .s_tready   (s_axis_tready),
        .s_tdata    (s_axis_tdata),
        .m_tvalid   (m_axis_tvalid),
        .m_tready   (m_axis_tready),
        .m_tdata    (m_axis_tdata),
        .m_tlast    (m_axis_tlast),
        .fail_count (fail_count),
        .pending    (pending),
        .words_seen (words_seen),
        .bits_seen  (bits_seen)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run limit
    initial
    begin
        #20ms;
        $display("gcr_sector_bit_decoder verification failed");
        $finish;
    end

    // one bit beat, with an idle gap drawn first
    task automatic put_bit(input logic b);
        int gap;
        int r;
        logic [31:0] pos;
        gap = burst ? 0 : $urandom_range(0, 14);
        r = $urandom_range(0, 15);
        pos = (r == 0) ? 32'h0 : (r == 1) ? 32'hffff_ffff : 32'($urandom);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, pos, b};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic put_byte(input logic [7:0] v);
        if ($urandom_range(0, 3) == 0)
            burst = ~burst;
        for (int i = 7; i >= 0; i--)
            put_bit(v[i]);
    endtask

    task automatic put_noise(input int n);
        for (int i = 0; i < n; i++)
            put_bit($urandom_range(0, 1));
    endtask

    // self-sync run then an address field, 4-and-4 coded
    task automatic put_addr(input bit mode62, input logic [7:0] vol,
                            input logic [7:0] trk, input logic [7:0] sec, input bit good);
        logic [7:0] f [4];
        f[0] = vol;
        f[1] = trk;
        f[2] = sec;
        f[3] = vol ^ trk ^ sec ^ (good ? 8'h00 : 8'h01 << $urandom_range(0, 7));
        repeat (4) put_byte(8'hff);
        put_byte(gsbd_pkg::MARK_ADDR62[23:16]);
        put_byte(gsbd_pkg::MARK_ADDR62[15:8]);
        put_byte(mode62 ? gsbd_pkg::MARK_ADDR62[7:0] : gsbd_pkg::MARK_ADDR53[7:0]);
        for (int i = 0; i < 4; i++)
        begin
            put_byte((f[i] >> 1) | 8'haa);
            put_byte(f[i] | 8'haa);
        end
        put_byte(8'hde);
        put_byte(8'haa);
        sectors_sent++;
    endtask

    // self-sync run then a data field of the given kind
    task automatic put_data(input field_kind_t kind);
        logic [5:0] chain [343];
        logic [5:0] prev;
        repeat (4) put_byte(8'hff);
        put_byte(gsbd_pkg::MARK_DATA[23:16]);
        put_byte(gsbd_pkg::MARK_DATA[15:8]);
        put_byte(gsbd_pkg::MARK_DATA[7:0]);
        if (kind == DF_53)
        begin
            for (int i = 0; i < 411; i++)
                put_byte(8'($urandom));
        end
        else
        begin
            for (int i = 0; i < 343; i++)
                chain[i] = 6'($urandom);
            chain[342] = (kind == DF_BAD_SUM) ? 6'($urandom_range(1, 63)) : 6'd0;
            prev = 6'd0;
            for (int i = 0; i < 343; i++)
            begin
                // unknown disk bytes (values 00 and 80 are never codes)
                if (kind == DF_UNKNOWN && $urandom_range(0, 40) == 0)
                    put_byte($urandom_range(0, 1) ? 8'h80 : 8'h00);
                else
                    put_byte(GCR_CODES[chain[i] ^ prev]);
                prev = chain[i];
            end
        end
        put_byte(8'hde);
        put_byte(8'haa);
    endtask

    // receiver: random stall before each beat, bursts with no stall
    initial
    begin
        int gap;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
        end
    end

    // stimulus and verdict
    initial
    begin
        int kind;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        rst_n = 1'b0;
        burst = 1'b0;
        sectors_sent = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: data mark with no mode, then every field variant
        put_byte(gsbd_pkg::MARK_DATA[23:16]);
        put_byte(gsbd_pkg::MARK_DATA[15:8]);
        put_byte(gsbd_pkg::MARK_DATA[7:0]);
        put_noise(30);
        put_addr(1'b0, 8'h00, 8'h00, 8'h00, 1'b1);
        put_data(DF_53);
        put_addr(1'b1, 8'hff, 8'hff, 8'hff, 1'b1);
        put_data(DF_GOOD);
        put_addr(1'b1, 8'hfe, 8'h23, 8'h0f, 1'b0);
        put_data(DF_GOOD);
        put_addr(1'b1, 8'h01, 8'h11, 8'h05, 1'b1);
        put_data(DF_BAD_SUM);
        put_data(DF_GOOD);
        put_addr(1'b1, 8'h00, 8'h00, 8'h00, 1'b1);
        put_data(DF_GOOD);
        put_addr(1'b1, 8'h55, 8'h22, 8'h0c, 1'b1);
        put_data(DF_UNKNOWN);

        // random fields, mostly good sectors
        for (int n = 0; n < 8; n++)
        begin
            put_noise($urandom_range(0, 40));
            kind = $urandom_range(0, 9);
            if (kind < 6)
            begin
                put_addr(1'b1, 8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
                put_data(DF_GOOD);
            end
            else if (kind == 6)
            begin
                put_addr(1'b1, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
                put_data(DF_GOOD);
            end
            else if (kind == 7)
            begin
                put_addr(1'b1, 8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
                put_data(DF_BAD_SUM);
            end
            else if (kind == 8)
            begin
                put_addr(1'b1, 8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
            end
            else
            begin
                put_data(DF_GOOD);
            end
        end
        put_noise(40);
        s_axis_tvalid <= 1'b0;

        // drain, then allow for a decode walk with no output
        while (pending > 0)
            @(posedge clk);
        repeat (3000) @(posedge clk);

        $display("Sent %0d disk bits in %0d address fields; %0d sector words checked.",
                 bits_seen, sectors_sent, words_seen);
        if (fail_count == 0 && pending == 0)
            $display("gcr_sector_bit_decoder verification clean");
        else
            $display("gcr_sector_bit_decoder verification failed");
        $finish;
    end

endmodule
